/* src/bfd_pkg.sv */
package bfd_pkg;

   // Pixel channels, alpha first
   localparam int NUM_CH = 4;
   localparam int CH_W = 8;
   localparam int PIX_W = NUM_CH * CH_W;

   // Configuration registers
   localparam int SCALE_REG_W = 5;
   localparam int WIDTH_REG_W = 9;
   localparam logic [SCALE_REG_W-1:0] SCALE_RST = 5'd8;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RST = 9'd16;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ADD,
      ST_DIV,
      ST_OUT
   } bfd_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic read;
      logic write;
      logic div_start;
      logic load;
   } bfd_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic emit;
      logic div_done;
      logic out_free;
   } bfd_sts_type;

endpackage

/* src/box_filter_downscale_argb.sv */
// Box-filter downscaler for premultiplied ARGB pixels.
// req_*: source pixels in raster order, one transaction per pixel. req_tuser
//   is the frame start flag; it clears the block and column position.
//   A source row is out_width * scale pixels.
// rsp_*: one transaction per completed scale x scale block, channels
//   rounded to nearest (sum + n/2) / n, n = scale^2; rsp_tlast marks the
//   last pixel of an output row.
// csr_*: register writes, index 0 = scale, 1 = out_width; other indexes
//   are dropped. Write only while no pixel is in flight.
// Timing: one pixel at a time. A pixel that does not close a block passes
//   through accept, sum read and sum write. A closing pixel adds the serial
//   divider, one quotient bit per cycle over DVW bits (18 at defaults), and
//   the load of the output register; rsp_tvalid rises as req_tready returns.
// Reset: position counters clear, scale = 8, out_width = 16. Column sums
//   are not cleared; the first pixel of each block overwrites its sum.
// Stall: the result waits in an output register while rsp_tready is low;
//   further pixels are still taken until the next block closes.
module box_filter_downscale_argb
   import bfd_pkg::*;
#(
   parameter int MAX_OUT_WIDTH = 256,
   parameter int MAX_SCALE = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [PIX_W-1:0]        req_tdata,  // in_alpha, in_red, in_green, in_blue
   input  logic                    req_tuser,  // frame_start
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [PIX_W-1:0]        rsp_tdata,  // out_alpha, out_red, out_green, out_blue
   output logic                    rsp_tlast,  // row_end
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   bfd_cmd_type cmd;
   bfd_sts_type sts;

   // register writes never stall
   assign csr_ready = 1'b1;

   bfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bfd_dp #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
      .MAX_SCALE     (MAX_SCALE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .pix_in         (req_tdata),
      .frame_start_in (req_tuser),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast)
   );

endmodule

/* src/bfd_div.sv */
module bfd_div
   import bfd_pkg::*;
#(
   parameter int DVW = 18,
   parameter int NW = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [NUM_CH-1:0][DVW-1:0]      dividend,
   input  logic [NW-1:0]                   divisor,
   output logic                            busy,
   output logic [NUM_CH-1:0][DVW-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVW + 1);

   logic                        busy_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [NUM_CH-1:0][DVW-1:0]  dvd_ff, dvd_in;
   logic [NUM_CH-1:0][NW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]               dsr_ff;
   logic [NUM_CH-1:0][NW:0]     rem_w;
   logic [NUM_CH-1:0]           ge;

   // restoring division, one quotient bit per cycle, all channels in parallel
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         rem_w[c] = {rem_ff[c], dvd_ff[c][DVW-1]};
         ge[c] = rem_w[c] >= {1'b0, dsr_ff};
         rem_in[c] = ge[c] ? NW'(rem_w[c] - {1'b0, dsr_ff}) : NW'(rem_w[c]);
         dvd_in[c] = {dvd_ff[c][DVW-2:0], ge[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVW - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign quotient = dvd_ff;

endmodule

/* src/bfd_dp.sv */
module bfd_dp
   import bfd_pkg::*;
#(
   parameter int MAX_OUT_WIDTH = 256,
   parameter int MAX_SCALE = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bfd_cmd_type             cmd,
   output bfd_sts_type             sts,
   input  logic [PIX_W-1:0]        pix_in,
   input  logic                    frame_start_in,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [PIX_W-1:0]        rsp_tdata,
   output logic                    rsp_tlast
);

   localparam int SW = $clog2(MAX_SCALE + 1);
   localparam int WW = $clog2(MAX_OUT_WIDTH + 1);
   localparam int CIB_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int OC_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int NW = 2 * SW;
   // one guard bit above the largest legal block sum
   localparam int SUM_W = CH_W + 2 * CIB_W + 1;
   localparam int DVW = SUM_W + 1;
   localparam int MEM_W = NUM_CH * SUM_W;

   logic [SCALE_REG_W-1:0]  scale_ff;
   logic [WIDTH_REG_W-1:0]  out_width_ff;
   logic [CIB_W-1:0]        cib_ff, rib_ff, cib_cur, rib_cur;
   logic [OC_W-1:0]         oc_ff, oc_cur, col;
   logic [SW-1:0]           s_eff;
   logic [WW-1:0]           w_eff;
   logic                    last_col, last_out, last_row;

   logic [OC_W-1:0]                 col_ff;
   logic                            first_ff, emit_ff, row_end_ff;
   logic [NUM_CH-1:0][CH_W-1:0]     pix_ff;
   logic [MEM_W-1:0]                mem [MAX_OUT_WIDTH];
   logic [NUM_CH-1:0][SUM_W-1:0]    rd_ff, sum_new;
   logic [NUM_CH-1:0][DVW-1:0]      dividend, quotient;
   logic [NW-1:0]                   n, half;
   logic                            div_busy;

   logic                            rsp_valid_ff;
   logic [NUM_CH-1:0][CH_W-1:0]     rsp_data_ff, avg;
   logic                            rsp_last_ff;

   // config registers, out-of-range values clamped on use
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RST;
         out_width_ff <= WIDTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SCALE:     scale_ff <= csr_wdata[SCALE_REG_W-1:0];
            REG_OUT_WIDTH: out_width_ff <= csr_wdata[WIDTH_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (scale_ff == '0) begin
         s_eff = SW'(1);
      end else if (int'(scale_ff) > MAX_SCALE) begin
         s_eff = SW'(MAX_SCALE);
      end else begin
         s_eff = SW'(scale_ff);
      end
      if (out_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(out_width_ff) > MAX_OUT_WIDTH) begin
         w_eff = WW'(MAX_OUT_WIDTH);
      end else begin
         w_eff = WW'(out_width_ff);
      end
   end

   // position of the incoming pixel; frame start clears it first
   always_comb begin
      cib_cur = frame_start_in ? '0 : cib_ff;
      rib_cur = frame_start_in ? '0 : rib_ff;
      oc_cur = frame_start_in ? '0 : oc_ff;
      col = (int'(oc_cur) >= int'(w_eff)) ? OC_W'(w_eff - 1'b1) : oc_cur;
      last_col = (int'(cib_cur) + 1) >= int'(s_eff);
      last_out = (int'(oc_cur) + 1) >= int'(w_eff);
      last_row = (int'(rib_cur) + 1) >= int'(s_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cib_ff <= '0;
         oc_ff <= '0;
         rib_ff <= '0;
      end else if (cmd.accept) begin
         if (last_col) begin
            cib_ff <= '0;
            if (last_out) begin
               oc_ff <= '0;
               rib_ff <= last_row ? '0 : rib_cur + 1'b1;
            end else begin
               oc_ff <= oc_cur + 1'b1;
               rib_ff <= rib_cur;
            end
         end else begin
            cib_ff <= cib_cur + 1'b1;
            oc_ff <= oc_cur;
            rib_ff <= rib_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= pix_in;
         col_ff <= col;
         first_ff <= (cib_cur == '0) && (rib_cur == '0);
         emit_ff <= last_col && last_row;
         row_end_ff <= last_out;
      end
   end

   // column sum memory, all four channels in one word
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_ff <= mem[col_ff];
      end
      if (cmd.write) begin
         mem[col_ff] <= sum_new;
      end
   end

   always_comb begin
      n = NW'(s_eff) * NW'(s_eff);
      half = n >> 1;
      for (int c = 0; c < NUM_CH; c++) begin
         sum_new[c] = first_ff ? SUM_W'(pix_ff[c]) : rd_ff[c] + SUM_W'(pix_ff[c]);
         dividend[c] = DVW'(sum_new[c]) + DVW'(half);
      end
   end

   bfd_div #(
      .DVW (DVW),
      .NW  (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (n),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         avg[c] = (quotient[c][DVW-1:CH_W] != '0) ? '1 : quotient[c][CH_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= avg;
         rsp_last_ff <= row_end_ff;
      end
   end

   assign sts.emit = emit_ff;
   assign sts.div_done = !div_busy;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

/* src/bfd_ctrl.sv */
module bfd_ctrl
   import bfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  bfd_sts_type   sts,
   output bfd_cmd_type   cmd
);

   bfd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.write = 1'b1;
            if (sts.emit) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_READ) && cmd.read)
      else $error("accepted transaction not followed by sum read");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> sts.out_free)
      else $error("result register overwritten");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !sts.div_done)
      else $error("divider did not start");
`endif

endmodule

/* verif/tb_box_filter_downscale_argb.sv */
module tb_box_filter_downscale_argb;
   timeunit 1ns;
   timeprecision 1ps;
   import bfd_pkg::*;

   // Block sizes, kept at the block's defaults
   localparam int MAX_W = 256;
   localparam int MAX_S = 16;
   localparam int unsigned CH_MAX = (1 << CH_W) - 1;
   localparam int unsigned SCALE_RAW_MAX = (1 << SCALE_REG_W) - 1;
   localparam int unsigned WIDTH_RAW_MAX = (1 << WIDTH_REG_W) - 1;

   // Register indexes past the list; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;

   // Settle time covers one pixel still in flight
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PIXELS = 520;
   localparam int IDLE_PCT = 21;
   localparam int REPORT_MAX = 10;

   // Channel layout on tdata: alpha in the low byte, blue in the top byte
   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] alpha;
   } argb_type;

   typedef struct packed {
      argb_type pix;
      logic     row_end;
   } box_avg_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   argb_type              req_tdata = '0;     // in_alpha, in_red, in_green, in_blue
   logic                  req_tuser = 1'b0;   // frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;          // out_alpha, out_red, out_green, out_blue
   logic                  rsp_tlast;          // row_end
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the block: registers, column sums and raster position
   logic [SCALE_REG_W-1:0] cfg_scale = SCALE_RST;
   logic [WIDTH_REG_W-1:0] cfg_width = WIDTH_RST;
   int unsigned col_sum [MAX_W][NUM_CH];
   int unsigned pos_col = 0;   // column inside the current block
   int unsigned pos_out = 0;   // output column
   int unsigned pos_row = 0;   // row inside the current block

   box_avg_type pending_avgs [$];
   int unsigned pixels_sent = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          throttle = 1'b1;   // random idling on both sides when set

   box_filter_downscale_argb #(
      .MAX_OUT_WIDTH(MAX_W),
      .MAX_SCALE(MAX_S)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   // Register values outside the legal range act as the nearest end
   function automatic int unsigned clamp_scale(input logic [SCALE_REG_W-1:0] raw);
      if (raw == 0) return 1;
      return (raw > MAX_S) ? MAX_S : raw;
   endfunction

   function automatic int unsigned clamp_width(input logic [WIDTH_REG_W-1:0] raw);
      if (raw == 0) return 1;
      return (raw > MAX_W) ? MAX_W : raw;
   endfunction

   // Accumulates one source pixel; queues the block average when the
   // pixel closes a scale x scale block.
   function automatic void predict_box_average(input logic fs, input argb_type px);
      int unsigned s, w, col, n, avg, ch;
      logic [PIX_W-1:0] chans;
      logic [PIX_W-1:0] avgs;
      bit first, last_col, last_out, last_row;
      box_avg_type res;
      s = clamp_scale(cfg_scale);
      w = clamp_width(cfg_width);
      if (fs) begin
         pos_col = 0;
         pos_out = 0;
         pos_row = 0;
      end
      // a position left past a shrunken width sticks to the last column
      col = (pos_out >= w) ? w - 1 : pos_out;
      first = (pos_col == 0) && (pos_row == 0);
      chans = px;
      for (ch = 0; ch < NUM_CH; ch++) begin
         col_sum[col][ch] = (first ? 0 : col_sum[col][ch]) + chans[ch*CH_W +: CH_W];
      end
      last_col = (pos_col + 1) >= s;
      last_out = (pos_out + 1) >= w;
      last_row = (pos_row + 1) >= s;
      if (last_col && last_row) begin
         n = s * s;
         for (ch = 0; ch < NUM_CH; ch++) begin
            avg = (col_sum[col][ch] + n / 2) / n;
            if (avg > CH_MAX) avg = CH_MAX;   // only after a register change mid-frame
            avgs[ch*CH_W +: CH_W] = avg[CH_W-1:0];
         end
         res.pix = avgs;
         res.row_end = last_out;
         pending_avgs.push_back(res);
      end
      if (last_col) begin
         pos_col = 0;
         if (last_out) begin
            pos_out = 0;
            pos_row = last_row ? 0 : pos_row + 1;
         end else begin
            pos_out++;
         end
      end else begin
         pos_col++;
      end
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%0t ns: %s", $realtime, msg);
   endtask

   task automatic check_channel(input string name, input logic [CH_W-1:0] want,
                                input logic [CH_W-1:0] got);
      if (got !== want)
         note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   // Each result transaction against the oldest queued average
   always @(posedge clock) begin : check_results
      box_avg_type want;
      argb_type    got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_avgs.size() == 0) begin
            note_mismatch($sformatf("result with none queued: data %h row_end %b",
                                    rsp_tdata, rsp_tlast));
         end else begin
            want = pending_avgs.pop_front();
            check_channel("out_alpha", want.pix.alpha, got.alpha);
            check_channel("out_red", want.pix.red, got.red);
            check_channel("out_green", want.pix.green, got.green);
            check_channel("out_blue", want.pix.blue, got.blue);
            if (rsp_tlast !== want.row_end)
               note_mismatch($sformatf("row_end expected %b got %b",
                                       want.row_end, rsp_tlast));
         end
      end
   end

   // Result side back-pressure, changed at the falling edge
   always @(negedge clock) begin
      rsp_tready <= !throttle || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("box_filter_downscale_argb: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers; all start and end at a falling edge
   // ---------------------------------------------------------------

   function automatic argb_type rand_pixel();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 12) return '1;
      if (pick < 22) return '0;
      return argb_type'($urandom);
   endfunction

   // One pixel transaction; req_tvalid stays high on return so that a
   // following pixel can go out back to back.
   task automatic send_pixel(input logic fs, input argb_type px);
      while (throttle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      req_tuser <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_box_average(fs, px);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Stop sending and wait for every queued average; with settle, also let
   // a pixel that closes no block leave the pipeline.
   task automatic hold_sender(input bit settle);
      req_tvalid <= 1'b0;
      while (pending_avgs.size() != 0) @(negedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
      @(negedge clock);
   endtask

   // csr_valid is left high so writes can follow back to back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_SCALE) cfg_scale = val[SCALE_REG_W-1:0];
      else if (idx == REG_OUT_WIDTH) cfg_width = val[WIDTH_REG_W-1:0];
      @(negedge clock);
   endtask

   // Registers change only with the block idle. Bits above each register
   // carry noise; spare indexes get random writes that must not land.
   task automatic set_config(input int unsigned scale_raw, input int unsigned width_raw,
                             input bit spare_writes);
      logic [CSR_DATA_W-1:0] d;
      hold_sender(1'b1);
      d = CSR_DATA_W'($urandom);
      d[SCALE_REG_W-1:0] = SCALE_REG_W'(scale_raw);
      write_reg(REG_SCALE, d);
      d = CSR_DATA_W'($urandom);
      d[WIDTH_REG_W-1:0] = WIDTH_REG_W'(width_raw);
      write_reg(REG_OUT_WIDTH, d);
      if (spare_writes) begin
         write_reg(REG_SPARE_LO, CSR_DATA_W'($urandom));
         write_reg(REG_SPARE_HI, CSR_DATA_W'($urandom));
      end
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // A raster of rows x row_len pixels. May be cut short or restarted by a
   // stray frame_start; opaque forces alpha to full scale.
   task automatic send_frame(input int unsigned rows, input int unsigned row_len,
                             input bit fs_first, input bit opaque, input bit may_break);
      int unsigned total, cut, restart_at, k;
      argb_type px;
      total = rows * row_len;
      cut = total;
      restart_at = total;
      if (may_break && $urandom_range(99) < 10) cut = $urandom_range(1, total);
      if (may_break && $urandom_range(99) < 8) restart_at = $urandom_range(1, total);
      for (k = 0; k < cut; k++) begin
         if ($urandom_range(99) < 2) hold_sender(1'b0);
         px = rand_pixel();
         if (opaque) px.alpha = '1;
         send_pixel((k == 0 && fs_first) || (k == restart_at), px);
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset values: scale 8, width 16. Too few pixels to close a block, so
   // nothing may come out.
   task automatic test_reset_defaults();
      send_pixel(1'b1, rand_pixel());
      send_pixel(1'b0, rand_pixel());
      send_pixel(1'b0, rand_pixel());
      hold_sender(1'b1);
   endtask

   // Scale 0 and width 0 act as 1: every pixel is its own block and row end.
   // Also checks that the spare indexes are ignored.
   task automatic test_unit_blocks();
      set_config(0, 0, 1'b1);
      send_pixel(1'b1, '0);
      send_pixel(1'b0, '1);
      send_pixel(1'b0, argb_type'(32'h55AA_55AA));
   endtask

   // Scale 2, width 2: first block hits round-half-up, round-down and
   // full scale; second block random.
   task automatic test_rounding();
      argb_type corner;
      argb_type plain;
      int unsigned r, c;
      corner = '{blue: 8'd3, green: 8'd255, red: 8'd1, alpha: 8'd2};
      plain = '{blue: 8'd0, green: 8'd255, red: 8'd0, alpha: 8'd0};
      set_config(2, 2, 1'b0);
      for (r = 0; r < 2; r++) begin
         for (c = 0; c < 4; c++) begin
            if (c >= 2) send_pixel(1'b0, rand_pixel());
            else if (r == 0 && c == 0) send_pixel(1'b1, corner);
            else send_pixel(1'b0, plain);
         end
      end
   endtask

   // Registers shrink mid-frame with the block idle: block and column
   // position sit past the new limits, and the average of a sum built
   // from five full-scale pixels over n = 1 saturates.
   task automatic test_midframe_change();
      int unsigned k;
      set_config(2, 3, 1'b0);
      // full first row plus most of the second; stops one pixel into column 2
      for (k = 0; k < 11; k++) send_pixel(k == 0, '1);
      set_config(1, 2, 1'b0);
      send_pixel(1'b0, '1);
   endtask

   // A short run of small random frames, some broken, with two frames at
   // the register extremes early in the run.
   task automatic test_random_frames();
      int unsigned start, s_raw, w_raw, s, w, out_rows;
      int unsigned scale_top_mark, width_top_mark;
      bit scale_top_done, width_top_done, fresh, opaque, may_break, one_row;
      start = pixels_sent;
      scale_top_mark = $urandom_range(30, 45);
      width_top_mark = $urandom_range(45, 60);
      scale_top_done = 1'b0;
      width_top_done = 1'b0;
      fresh = 1'b1;   // position left mid-frame by the previous test
      while (pixels_sent - start < RANDOM_PIXELS) begin
         // the opening frames run with no idling at all
         throttle = (pixels_sent - start >= 30);
         opaque = 1'b0;
         may_break = 1'b1;
         one_row = 1'b0;
         if (!scale_top_done && pixels_sent - start >= scale_top_mark) begin
            // largest block: 16 x 16 pixels of an opaque image, one column
            scale_top_done = 1'b1;
            fresh = 1'b1;
            opaque = 1'b1;
            may_break = 1'b0;
            one_row = 1'b1;
            s_raw = $urandom_range(MAX_S, SCALE_RAW_MAX);
            w_raw = $urandom_range(0, 1);
         end else if (!width_top_done && pixels_sent - start >= width_top_mark) begin
            // widest row at unit scale
            width_top_done = 1'b1;
            fresh = 1'b1;
            may_break = 1'b0;
            one_row = 1'b1;
            s_raw = $urandom_range(0, 1);
            w_raw = $urandom_range(MAX_W, WIDTH_RAW_MAX);
         end else if (fresh || $urandom_range(99) < 70) begin
            fresh = 1'b1;
            case ($urandom_range(9))
               0:       s_raw = 0;
               8, 9:    s_raw = $urandom_range(4, 5);
               default: s_raw = $urandom_range(1, 3);
            endcase
            case ($urandom_range(9))
               0:       w_raw = 0;
               7, 8, 9: w_raw = $urandom_range(5, 10);
               default: w_raw = $urandom_range(1, 4);
            endcase
            if (clamp_scale(SCALE_REG_W'(s_raw)) >= 4 && w_raw > 3)
               w_raw = $urandom_range(1, 3);
         end
         if (fresh) set_config(s_raw, w_raw, $urandom_range(99) < 20);
         s = clamp_scale(cfg_scale);
         w = clamp_width(cfg_width);
         out_rows = (one_row || s * s * w > 48) ? 1 : $urandom_range(1, 3);
         // same registers: the raster may simply continue without a new frame start
         send_frame(s * out_rows, s * w, fresh || $urandom_range(1), opaque, may_break);
         fresh = 1'b0;
      end
      throttle = 1'b1;
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_unit_blocks();
      test_rounding();
      test_midframe_change();
      test_random_frames();

      // drain, then give the pipeline time to show anything spurious
      hold_sender(1'b1);
      if (mismatches == 0) begin
         $display("box_filter_downscale_argb: match");
      end else begin
         $display("box_filter_downscale_argb: mismatch");
      end
      $finish;
   end

endmodule

/* box_filter_downscale_argb.f */
src/bfd_pkg.sv
src/bfd_div.sv
src/bfd_dp.sv
src/bfd_ctrl.sv
src/box_filter_downscale_argb.sv
verif/tb_box_filter_downscale_argb.sv
